FILE: design/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define STVT_AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define STVT_AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

FILE: design/stvt_pkg.sv
// shared types and constants of the sorted tag/value table
// no dependencies; imported by every module of the block
`default_nettype none

package stvt_pkg;

  localparam int CAPACITY = 16;
  localparam int CIDX_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LIST_MAX = (CAPACITY < 16) ? CAPACITY : 16;

  localparam int FUNC_W   = 2;
  localparam int TAG_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_GET    = 2'd2,
    FN_LIST   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5,
    ST_LIST      = 3'd6
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic compare;
    logic exec;
    logic list_emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic list_multi;
    logic list_end;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/stvt_datapath.sv
// datapath: request register, cell chain of tags and values, output stage
// depends on stvt_pkg
`default_nettype none

module stvt_datapath import stvt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [TAG_W-1:0]    in_tag,
  input  wire logic [VAL_W-1:0]    in_value,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [TAG_W-1:0]         out_tag,
  output logic [VAL_W-1:0]         out_value,
  output logic [ENTRY_W-1:0]       out_entry_count,
  output logic                     out_last
);

  // request registers
  func_t              func_r;
  logic [TAG_W-1:0]   req_tag_r;
  logic [VAL_W-1:0]   req_val_r;

  // cell chain
  logic [TAG_W-1:0]   tag_r   [CAPACITY];
  logic [VAL_W-1:0]   val_r   [CAPACITY];
  logic [TAG_W-1:0]   tag_nxt [CAPACITY];
  logic [VAL_W-1:0]   val_nxt [CAPACITY];
  logic [CNT_W-1:0]   count_r, count_nxt;

  // compare results, one bit per cell
  logic [CAPACITY-1:0] lt_r, lt_nxt;
  logic [CAPACITY-1:0] hit_r, hit_nxt;
  logic [CAPACITY-1:0] ins_at, shift_in;

  // list walk
  logic [CIDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]   list_n;
  logic               list_last;

  logic               hit_any;
  logic               full;
  logic [VAL_W-1:0]   get_val;

  // output stage
  logic               out_valid_r;
  status_t            out_status_r, status_nxt;
  logic [TAG_W-1:0]   out_tag_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [ENTRY_W-1:0] out_count_r;
  logic               out_last_r;

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= func_t'(in_func);
      req_tag_r <= in_tag;
      req_val_r <= in_value;
    end
  end

  // every live cell compares against the request tag
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_nxt[i]  = (CNT_W'(i) < count_r) && (tag_r[i] < req_tag_r);
      hit_nxt[i] = (CNT_W'(i) < count_r) && (tag_r[i] == req_tag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt_r  <= lt_nxt;
      hit_r <= hit_nxt;
    end
  end

  // lt is a prefix: insert point is its first zero
  assign ins_at   = ~lt_r & {lt_r[CAPACITY-2:0], 1'b1};
  assign shift_in = ~lt_r & ~{lt_r[CAPACITY-2:0], 1'b1};
  assign hit_any  = |hit_r;
  assign full     = (count_r == CNT_W'(CAPACITY));

  // value of the matching cell
  always_comb begin
    get_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_r[i]) get_val = get_val | val_r[i];
    end
  end

  // table update on execute
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      tag_nxt[i] = tag_r[i];
      val_nxt[i] = val_r[i];
    end
    count_nxt = count_r;
    if (cmd.exec) begin
      unique case (func_r)
        FN_ADD: begin
          if (hit_any) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (hit_r[i]) val_nxt[i] = req_val_r;
            end
          end else if (!full) begin
            for (int i = 1; i < CAPACITY; i++) begin
              if (shift_in[i]) begin
                tag_nxt[i] = tag_r[i-1];
                val_nxt[i] = val_r[i-1];
              end
            end
            for (int i = 0; i < CAPACITY; i++) begin
              if (ins_at[i]) begin
                tag_nxt[i] = req_tag_r;
                val_nxt[i] = req_val_r;
              end
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_REMOVE: begin
          if (hit_any) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (!lt_r[i]) begin
                tag_nxt[i] = tag_r[i+1];
                val_nxt[i] = val_r[i+1];
              end
            end
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_GET, FN_LIST: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      tag_r[i] <= tag_nxt[i];
      val_r[i] <= val_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // list walk index
  assign list_n    = (count_r > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : count_r;
  assign list_last = ((CNT_W'(idx_r) + CNT_W'(1)) == list_n);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx_r <= '0;
    end else if (cmd.list_emit) begin
      idx_r <= idx_r + CIDX_W'(1);
    end
  end

  // status of a single-result request
  always_comb begin
    unique case (func_r)
      FN_ADD:    status_nxt = hit_any ? ST_REPLACED : (full ? ST_FULL : ST_INSERTED);
      FN_REMOVE: status_nxt = hit_any ? ST_REMOVED : ST_NOT_FOUND;
      FN_GET:    status_nxt = hit_any ? ST_FOUND : ST_NOT_FOUND;
      FN_LIST:   status_nxt = ST_NOT_FOUND;
      default:   status_nxt = ST_NOT_FOUND;
    endcase
  end

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.list_multi = (func_r == FN_LIST) && (count_r != '0);
  assign sts.list_end   = list_last;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.exec && !sts.list_multi) || cmd.list_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.list_emit) begin
      out_status_r <= ST_LIST;
      out_tag_r    <= tag_r[idx_r];
      out_value_r  <= val_r[idx_r];
      out_count_r  <= ENTRY_W'(count_r);
      out_last_r   <= list_last;
    end else if (cmd.exec && !sts.list_multi) begin
      out_status_r <= status_nxt;
      out_tag_r    <= req_tag_r;
      out_value_r  <= (func_r == FN_GET && hit_any) ? get_val : '0;
      out_count_r  <= ENTRY_W'(count_nxt);
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_tag         = out_tag_r;
  assign out_value       = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

FILE: design/stvt_ctrl.sv
// controller: sequences capture, compare, execute and list walk
// depends on stvt_pkg
`default_nettype none

module stvt_ctrl import stvt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_EXEC = 4'b0100,
    S_LIST = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // take a new item when idle or while a single-result request executes
  assign in_stall = !((state_r == S_IDLE) ||
                      ((state_r == S_EXEC) && sts.out_free && !sts.list_multi));
  assign accept   = in_valid && !in_stall;

  // commands to the datapath
  assign cmd.capture   = accept;
  assign cmd.compare   = (state_r == S_CMP);
  assign cmd.exec      = (state_r == S_EXEC) && sts.out_free;
  assign cmd.list_emit = (state_r == S_LIST) && sts.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.out_free) begin
          if (sts.list_multi) state_nxt = S_LIST;
          else if (accept)    state_nxt = S_CMP;
          else                state_nxt = S_IDLE;
        end
      end
      S_LIST: if (sts.out_free && sts.list_end) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/sorted_tag_value_table_unit.sv
// Sorted tag/value table: up to CAPACITY (16) entries of 32-bit tag and
// 32-bit value, kept in ascending unsigned tag order in a chain of cells.
// Input channel in_valid/in_stall carries one item: in_func (0 add or
// replace, 1 remove, 2 get, 3 list), in_tag, in_value.
// Result channel out_valid/out_stall carries out_status, out_tag, out_value,
// out_entry_count (entries held after the request) and out_last.
// Add, remove and get give one result; list gives one result per entry,
// last one marked, or a single not-found result on an empty table.
// Timing: an item is captured in the request register, then passes the cell
// compare and the execute step, which loads its result into the output
// register; a new item can be taken while a single-result request executes.
// A list uses the execute step to start the walk and then emits one entry per
// cycle while the output register is free, set by the single read port of the
// cell chain; the next item is taken only after the walk has ended.
// A result waits in the output register while out_stall is high; the block
// stalls its input and holds its state until that register frees up.
// Reset (rst_n low, synchronous) empties the table and drops any result.
// depends on stvt_pkg, stvt_ctrl, stvt_datapath
`default_nettype none

module sorted_tag_value_table_unit import stvt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [TAG_W-1:0]    in_tag,
  input  wire logic [VAL_W-1:0]    in_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [TAG_W-1:0]         out_tag,
  output logic [VAL_W-1:0]         out_value,
  output logic [ENTRY_W-1:0]       out_entry_count,
  output logic                     out_last
);

  cmd_t cmd;
  sts_t sts;

  stvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  stvt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_tag          (in_tag),
    .in_value        (in_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_value       (out_value),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

FILE: design/stvt_checker.sv
// port-level checks of the sorted tag/value table, bound to the top level
// depends on stvt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stvt_checker import stvt_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [TAG_W-1:0]    out_tag,
  input wire logic [VAL_W-1:0]    out_value,
  input wire logic [ENTRY_W-1:0]  out_entry_count,
  input wire logic                out_last
);

  logic                               out_wait;
  logic [STATUS_W+TAG_W+VAL_W:0]      out_bundle;
  logic                               out_single;
  logic                               out_entry;
  logic                               out_plain;

  assign out_wait   = out_valid && out_stall;
  assign out_bundle = {out_status, out_tag, out_value, out_last};
  assign out_single = out_valid && (out_status != ST_LIST);
  assign out_entry  = out_valid && (out_status == ST_LIST);
  assign out_plain  = out_single && (out_status != ST_FOUND);

  // a stalled result stays put
  `STVT_AST_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_bundle))

  // an accepted item is compared first, so no item right after it
  `STVT_AST_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)

  // every result other than a list entry closes its request
  `STVT_AST_IMPLY(a_single_last, clk, rst_n, out_single, out_last)

  // a list entry only comes from a non-empty table
  `STVT_AST_IMPLY(a_list_count, clk, rst_n, out_entry, out_entry_count != '0)

  // only found and list results carry a value
  `STVT_AST_IMPLY(a_value_zero, clk, rst_n, out_plain, out_value == '0)

endmodule

bind sorted_tag_value_table_unit stvt_checker u_stvt_checker (.*);

`default_nettype wire

FILE: dv/sorted_tag_value_table_unit_tb.sv
// testbench of the sorted tag/value table: directed and random requests
// against an in-bench model of the table; depends on stvt_pkg and the unit
`default_nettype none

module sorted_tag_value_table_unit_tb;
  import stvt_pkg::*;

  // one reply item as the unit should deliver it
  typedef struct {
    status_t          status;
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
    logic [ENTRY_W-1:0] count;
    logic             last;
  } table_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = FN_ADD;
  logic [TAG_W-1:0]    in_tag = '0;
  logic [VAL_W-1:0]    in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_tag;
  logic [VAL_W-1:0]    out_value;
  logic [ENTRY_W-1:0]  out_entry_count;
  logic                out_last;

  // model copy of the table
  logic [TAG_W-1:0] mdl_tags [CAPACITY];
  logic [VAL_W-1:0] mdl_vals [CAPACITY];
  int               mdl_held = 0;

  table_reply_t     due_replies[$];
  logic [TAG_W-1:0] tag_pool [8];
  bit               calm = 1'b0;
  int               errors = 0;
  int               items_sent = 0;
  int               replies_checked = 0;

  sorted_tag_value_table_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_tag          (in_tag),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_value       (out_value),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // queue one reply item
  task automatic push_reply(input status_t st, input logic [TAG_W-1:0] t,
                            input logic [VAL_W-1:0] v, input logic lst);
    table_reply_t r;
    r.status = st;
    r.tag    = t;
    r.value  = v;
    r.count  = mdl_held[ENTRY_W-1:0];
    r.last   = lst;
    due_replies.push_back(r);
  endtask

  // update the model table for one request and queue its replies
  task automatic apply_table_request(input func_t f, input logic [TAG_W-1:0] t,
                                     input logic [VAL_W-1:0] v);
    int  pos;
    int  i;
    int  n;
    bit  hit;
    pos = 0;
    while (pos < mdl_held && mdl_tags[pos] < t) pos++;
    hit = (pos < mdl_held) && (mdl_tags[pos] == t);
    case (f)
      FN_ADD: begin
        if (hit) begin
          mdl_vals[pos] = v;
          push_reply(ST_REPLACED, t, '0, 1'b1);
        end else if (mdl_held >= CAPACITY) begin
          push_reply(ST_FULL, t, '0, 1'b1);
        end else begin
          for (i = mdl_held; i > pos; i--) begin
            mdl_tags[i] = mdl_tags[i-1];
            mdl_vals[i] = mdl_vals[i-1];
          end
          mdl_tags[pos] = t;
          mdl_vals[pos] = v;
          mdl_held++;
          push_reply(ST_INSERTED, t, '0, 1'b1);
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < mdl_held; i++) begin
            mdl_tags[i] = mdl_tags[i+1];
            mdl_vals[i] = mdl_vals[i+1];
          end
          mdl_held--;
          push_reply(ST_REMOVED, t, '0, 1'b1);
        end else begin
          push_reply(ST_NOT_FOUND, t, '0, 1'b1);
        end
      end
      FN_GET: begin
        if (hit) push_reply(ST_FOUND, t, mdl_vals[pos], 1'b1);
        else push_reply(ST_NOT_FOUND, t, '0, 1'b1);
      end
      default: begin
        if (mdl_held == 0) begin
          push_reply(ST_NOT_FOUND, t, '0, 1'b1);
        end else begin
          n = (mdl_held < LIST_MAX) ? mdl_held : LIST_MAX;
          for (i = 0; i < n; i++)
            push_reply(ST_LIST, mdl_tags[i], mdl_vals[i], (i + 1 == n));
        end
      end
    endcase
  endtask

  // mismatch report: one line, counted
  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("%s got %h expected %h", name, got, exp));
  endtask

  // receiver stalls at random unless in a calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  // compare every accepted reply item with the oldest one due
  always @(posedge clk) begin : reply_check
    table_reply_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing due, tag %h", out_tag));
      end else begin
        exp_r = due_replies.pop_front();
        check_field("status", 32'(out_status), 32'(exp_r.status));
        check_field("tag", out_tag, exp_r.tag);
        check_field("value", out_value, exp_r.value);
        check_field("entry_count", 32'(out_entry_count), 32'(exp_r.count));
        check_field("last", 32'(out_last), 32'(exp_r.last));
        replies_checked++;
      end
    end
  end

  // send one request item, sometimes with a random gap in front of it
  task automatic send_item(input func_t f, input logic [TAG_W-1:0] t,
                           input logic [VAL_W-1:0] v);
    int gap;
    if (!calm && $urandom_range(0, 99) < 28) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_tag   <= t;
    in_value <= v;
    do @(posedge clk); while (in_stall === 1'b1);
    apply_table_request(f, t, v);
    items_sent++;
  endtask

  // hold the sender until every due reply has come back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tag mostly from the table or a small pool, sometimes fully random
  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && mdl_held > 0) return mdl_tags[$urandom_range(0, mdl_held - 1)];
    if (r < 80) return tag_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // remove every entry, highest first
  task automatic clear_table();
    while (mdl_held > 0)
      send_item(FN_REMOVE, mdl_tags[mdl_held - 1], $urandom());
  endtask

  // requests on an empty table
  task automatic test_empty_table();
    send_item(FN_LIST, 32'h1234_5678, 32'hFFFF_FFFF);
    send_item(FN_GET, 32'h0000_0000, 32'h0);
    send_item(FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
  endtask

  // extremes, replace, byte order, removal at both ends and the middle
  task automatic test_basic_ops();
    send_item(FN_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(FN_ADD, 32'h0000_0000, 32'h0000_0000);
    send_item(FN_ADD, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_item(FN_ADD, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_item(FN_ADD, 32'h0100_0000, 32'h0000_0001);
    send_item(FN_ADD, 32'h00FF_FFFF, 32'h8000_0000);
    send_item(FN_ADD, 32'h8000_0000, 32'h0000_0001);
    send_item(FN_GET, 32'h8000_0000, 32'h0);
    send_item(FN_GET, 32'h0000_0000, 32'h0);
    send_item(FN_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(FN_GET, 32'h8000_0001, 32'h0);
    send_item(FN_LIST, 32'hDEAD_BEEF, 32'h0);
    send_item(FN_REMOVE, 32'h7FFF_FFFF, 32'h0);
    send_item(FN_REMOVE, 32'h0000_0000, 32'h0);
    send_item(FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_item(FN_REMOVE, 32'h1357_9BDF, 32'h0);
    send_item(FN_LIST, 32'h0, 32'h0);
    clear_table();
  endtask

  // fill to capacity, insert into a full table, replace there, longest list
  task automatic test_full_table();
    int i;
    for (i = 0; i < CAPACITY; i++)
      send_item(FN_ADD, {8'(CAPACITY - i), 24'($urandom())}, $urandom());
    send_item(FN_ADD, 32'hFFFF_FFFF, 32'h1111_1111);
    send_item(FN_ADD, mdl_tags[CAPACITY / 2], 32'hFFFF_FFFF);
    send_item(FN_LIST, 32'h0, 32'h0);
    send_item(FN_REMOVE, mdl_tags[0], 32'h0);
    send_item(FN_ADD, 32'h0000_0000, 32'h2222_2222);
    send_item(FN_REMOVE, mdl_tags[CAPACITY - 1], 32'h0);
    send_item(FN_LIST, 32'h0, 32'h0);
    clear_table();
  endtask

  // sender waits for all replies at some points between requests
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 6; i++) send_item(FN_ADD, $urandom(), $urandom());
    wait_for_replies();
    send_item(FN_LIST, $urandom(), 32'h0);
    wait_for_replies();
    send_item(FN_GET, mdl_tags[0], 32'h0);
    send_item(FN_LIST, $urandom(), 32'h0);
  endtask

  // random request of a growing or shrinking mix
  task automatic send_random(input bit grow);
    int   r;
    func_t f;
    r = $urandom_range(0, 99);
    if (grow) f = (r < 55) ? FN_ADD : (r < 70) ? FN_REMOVE : (r < 90) ? FN_GET : FN_LIST;
    else f = (r < 15) ? FN_ADD : (r < 65) ? FN_REMOVE : (r < 90) ? FN_GET : FN_LIST;
    send_item(f, pick_tag(), $urandom());
  endtask

  // long random churn, table filling and draining in turns
  task automatic test_random_churn();
    int i;
    tag_pool[0] = 32'h0000_0000;
    tag_pool[1] = 32'hFFFF_FFFF;
    tag_pool[2] = 32'h7FFF_FFFF;
    tag_pool[3] = 32'h8000_0000;
    for (i = 4; i < 8; i++) tag_pool[i] = $urandom();
    for (i = 0; i < 240; i++) send_random(((i / 50) % 2) == 0);
  endtask

  // neither side idles for a while
  task automatic test_calm_stretch();
    int i;
    calm = 1'b1;
    for (i = 0; i < 40; i++) send_random((i % 20) < 12);
    wait_for_replies();
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_drain_pause();
    test_random_churn();
    test_calm_stretch();

    wait_for_replies();
    repeat (20) @(posedge clk);
    if (due_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never came", due_replies.size()));

    $display("covered %0d requests and %0d reply items: empty and full table,",
             items_sent, replies_checked);
    $display("replace, removal at both ends, longest list and random churn");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/stvt_pkg.sv
design/stvt_datapath.sv
design/stvt_ctrl.sv
design/sorted_tag_value_table_unit.sv
design/stvt_checker.sv
dv/sorted_tag_value_table_unit_tb.sv
